>>> hdl/pht_pkg.sv
// Shared types and constants of the polygon point hit test block.
package pht_pkg;

  localparam int MaxVertices = 64;
  localparam int AddrW = $clog2(MaxVertices);
  localparam int CntW = AddrW + 1;
  localparam int CoordW = 22;
  localparam int DiffW = CoordW + 1;
  localparam int ProdW = 2 * DiffW;
  localparam int SumW = ProdW + 1;
  localparam int SplitW = 24;
  localparam int PartW = 48;
  localparam int CmpW = 96;
  localparam int TolW = 12;
  localparam int TtW = 2 * TolW;
  localparam int RamW = 16 + 16 + 11;
  localparam int HandleHalf = 96;
  localparam int TolTwice = 160;
  localparam int RoundHalf = 512;
  localparam int ScaleShift = 10;

  localparam logic [2:0] CfgClosedMode = 3'd0;
  localparam logic [2:0] CfgVertexCount = 3'd1;
  localparam logic [2:0] CfgOffsetX = 3'd2;
  localparam logic [2:0] CfgOffsetY = 3'd3;
  localparam logic [2:0] CfgScaleX = 3'd4;
  localparam logic [2:0] CfgScaleY = 3'd5;

  typedef enum logic {
    OpLoad  = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [5:0]        vidx;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic [10:0]       thick;
    logic signed [20:0] qx;
    logic signed [20:0] qy;
  } item_t;

  typedef struct packed {
    logic              closed;
    logic [6:0]        vcount;
    logic signed [20:0] off_x;
    logic signed [20:0] off_y;
    logic [9:0]        scale_x;
    logic [9:0]        scale_y;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic [10:0]              thick;
    logic [AddrW-1:0]         idx;
    logic                     ray_en;
  } edge_in_t;

  typedef struct packed {
    logic             near;
    logic             toggle;
    logic [AddrW-1:0] idx;
  } edge_out_t;

  typedef struct packed {
    logic       in_poly;
    logic       vhit;
    logic [5:0] vidx;
    logic       shit;
    logic [5:0] sidx;
  } result_t;

endpackage

>>> hdl/polygon_point_hit_test.sv
// For n vertices in use, the vertex walk reads one vertex per cycle in closed and open mode.
// The back end takes one query at a time.
// A load is written into the vertex store when the back end takes it from the input queue,
// and loads can follow every cycle while the back end is idle.
// A stalled result holds the back end in its last step once the output register is full.
// Reset is asynchronous and active low; the vertex store is undefined until written.
module polygon_point_hit_test (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [5:0]         vertex_index_i,
  input  logic signed [15:0] base_x_i,
  input  logic signed [15:0] base_y_i,
  input  logic [10:0]        side_thickness_i,
  input  logic signed [20:0] query_x_i,
  input  logic signed [20:0] query_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               inside_res_o,
  output logic               vertex_hit_o,
  output logic [5:0]         hit_vertex_index_o,
  output logic               side_hit_o,
  output logic [5:0]         hit_side_index_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [20:0]        cfg_data_i
);
  import pht_pkg::*;

  cfg_t    cfg_q;
  item_t   in_item, q_item;
  logic    q_avail, q_pop;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.closed <= 1'b1;
      cfg_q.vcount <= 7'd2;
      cfg_q.off_x <= '0;
      cfg_q.off_y <= '0;
      cfg_q.scale_x <= 10'd100;
      cfg_q.scale_y <= 10'd100;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgClosedMode: cfg_q.closed <= cfg_data_i[0];
        CfgVertexCount: cfg_q.vcount <= cfg_data_i[6:0];
        CfgOffsetX: cfg_q.off_x <= signed'(cfg_data_i);
        CfgOffsetY: cfg_q.off_y <= signed'(cfg_data_i);
        CfgScaleX: cfg_q.scale_x <= cfg_data_i[9:0];
        CfgScaleY: cfg_q.scale_y <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{op: op_e'(operation_i), vidx: vertex_index_i,
                     base_x: base_x_i, base_y: base_y_i, thick: side_thickness_i,
                     qx: query_x_i, qy: query_y_i};

  pht_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .item_i    (in_item),
    .pop_i     (q_pop),
    .avail_o   (q_avail),
    .item_o    (q_item)
  );

  pht_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .avail_i    (q_avail),
    .item_i     (q_item),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign inside_res_o = res.in_poly;
  assign vertex_hit_o = res.vhit;
  assign hit_vertex_index_o = res.vidx;
  assign side_hit_o = res.shit;
  assign hit_side_index_o = res.sidx;

endmodule

>>> hdl/pht_ram.sv
// Generic single write port RAM with registered read.
module pht_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/pht_front.sv
// Input side: accepts items into a two entry queue for the back end.
module pht_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pht_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           avail_o,
  output pht_pkg::item_t item_o
);
  import pht_pkg::*;

  item_t      slot_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign push = in_valid_i && !in_stall_o;
  assign pop = pop_i && avail_o;
  assign item_o = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

>>> hdl/pht_edge.sv
// Pipelined side distance and ray crossing test for one edge per cycle.
module pht_edge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  pht_pkg::edge_in_t                 edge_i,
  input  logic signed [20:0]                qx_i,
  input  logic signed [20:0]                qy_i,
  output logic                              valid_o,
  output pht_pkg::edge_out_t                res_o
);
  import pht_pkg::*;

  logic [5:0] v_q;

  logic signed [DiffW-1:0] dx_q, dy_q, wx_q, wy_q, ex_q, ey_q;
  logic [TolW-1:0]         t_q;
  logic                    cross1_q;
  logic [AddrW-1:0]        idx1_q, idx2_q, idx3_q, idx4_q, idx5_q;

  logic signed [ProdW-1:0] dxx_q, dyy_q, wxdx_q, wydy_q, wxdy_q, wydx_q;
  logic signed [ProdW-1:0] wxx_q, wyy_q, exx_q, eyy_q, exdy_q, dxey_q;
  logic [TtW-1:0]          tt2_q, tt3_q;
  logic                    cross2_q, dyneg_q;

  logic [SumW-1:0]         l2_q, abscr_q, sa_q, sb_q;
  logic signed [SumW-1:0]  dot_q;
  logic                    tog3_q, tog4_q, tog5_q;

  logic [PartW-1:0]        hh_q, hl_q, ll_q, th_q, tl_q;
  logic                    skip4_q, end4_q, nend4_q;
  logic                    skip5_q, end5_q, nend5_q;
  logic [CmpW-1:0]         lhs_q, rhs_q;
  edge_out_t               res_q;

  logic signed [SumW-1:0] l2s, crs, sas, sbs;
  logic                   left;
  logic [SumW+1:0]        tt_wide;

  assign l2s = SumW'(dxx_q) + SumW'(dyy_q);
  assign crs = SumW'(wxdy_q) - SumW'(wydx_q);
  assign sas = SumW'(wxx_q) + SumW'(wyy_q);
  assign sbs = SumW'(exx_q) + SumW'(eyy_q);
  assign left = dyneg_q ? (exdy_q > dxey_q) : (exdy_q < dxey_q);
  assign tt_wide = (SumW + 2)'(tt3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= DiffW'(edge_i.bx) - DiffW'(edge_i.ax);
    dy_q <= DiffW'(edge_i.by) - DiffW'(edge_i.ay);
    wx_q <= DiffW'(qx_i) - DiffW'(edge_i.ax);
    wy_q <= DiffW'(qy_i) - DiffW'(edge_i.ay);
    ex_q <= DiffW'(qx_i) - DiffW'(edge_i.bx);
    ey_q <= DiffW'(qy_i) - DiffW'(edge_i.by);
    t_q <= TolW'(edge_i.thick) + TolW'(TolTwice);
    cross1_q <= edge_i.ray_en &&
                ((edge_i.by > CoordW'(qy_i)) != (edge_i.ay > CoordW'(qy_i)));
    idx1_q <= edge_i.idx;

    dxx_q <= dx_q * dx_q;
    dyy_q <= dy_q * dy_q;
    wxdx_q <= wx_q * dx_q;
    wydy_q <= wy_q * dy_q;
    wxdy_q <= wx_q * dy_q;
    wydx_q <= wy_q * dx_q;
    wxx_q <= wx_q * wx_q;
    wyy_q <= wy_q * wy_q;
    exx_q <= ex_q * ex_q;
    eyy_q <= ey_q * ey_q;
    exdy_q <= ex_q * dy_q;
    dxey_q <= dx_q * ey_q;
    tt2_q <= t_q * t_q;
    cross2_q <= cross1_q;
    dyneg_q <= dy_q[DiffW-1];
    idx2_q <= idx1_q;

    l2_q <= unsigned'(l2s);
    dot_q <= SumW'(wxdx_q) + SumW'(wydy_q);
    abscr_q <= crs[SumW-1] ? unsigned'(-crs) : unsigned'(crs);
    sa_q <= unsigned'(sas);
    sb_q <= unsigned'(sbs);
    tt3_q <= tt2_q;
    tog3_q <= cross2_q && left;
    idx3_q <= idx2_q;

    hh_q <= PartW'(abscr_q[SumW-1:SplitW]) * PartW'(abscr_q[SumW-1:SplitW]);
    hl_q <= PartW'(abscr_q[SumW-1:SplitW]) * PartW'(abscr_q[SplitW-1:0]);
    ll_q <= PartW'(abscr_q[SplitW-1:0]) * PartW'(abscr_q[SplitW-1:0]);
    th_q <= PartW'(tt3_q) * PartW'(l2_q[SumW-1:SplitW]);
    tl_q <= PartW'(tt3_q) * PartW'(l2_q[SplitW-1:0]);
    skip4_q <= (l2_q == '0);
    if (dot_q <= 0) begin
      end4_q <= 1'b1;
      nend4_q <= (((SumW + 2)'(sa_q)) << 2) <= tt_wide;
    end else begin
      end4_q <= (unsigned'(dot_q) >= l2_q);
      nend4_q <= (((SumW + 2)'(sb_q)) << 2) <= tt_wide;
    end
    tog4_q <= tog3_q;
    idx4_q <= idx3_q;

    lhs_q <= (CmpW'(hh_q) << 50) + (CmpW'(hl_q) << 27) + (CmpW'(ll_q) << 2);
    rhs_q <= (CmpW'(th_q) << SplitW) + CmpW'(tl_q);
    skip5_q <= skip4_q;
    end5_q <= end4_q;
    nend5_q <= nend4_q;
    tog5_q <= tog4_q;
    idx5_q <= idx4_q;

    res_q.near <= !skip5_q && (end5_q ? nend5_q : (lhs_q <= rhs_q));
    res_q.toggle <= tog5_q;
    res_q.idx <= idx5_q;
  end

  assign valid_o = v_q[5];
  assign res_o = res_q;

endmodule

>>> hdl/pht_back.sv
// Back end: vertex store, vertex walk and result collection for queries.
module pht_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pht_pkg::cfg_t    cfg_i,
  input  logic             avail_i,
  input  pht_pkg::item_t   item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pht_pkg::result_t res_o
);
  import pht_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDone
  } state_e;

  localparam logic signed [DiffW-1:0] BoxHi = DiffW'(HandleHalf);
  localparam logic signed [DiffW-1:0] BoxLo = -BoxHi;
  localparam logic signed [26:0] Round = 27'(RoundHalf);

  state_e state_q;
  logic [CntW-1:0] rd_cnt_q, edge_cnt_q;
  logic signed [20:0] qx_q, qy_q;
  logic vhit_q, shit_q, inside_q, wrap_q;
  logic [AddrW-1:0] vidx_q, sidx_q;
  logic out_valid_q;
  result_t res_q;

  logic r_v_q, m_v_q, p_v_q;
  logic r_last_q, m_last_q, p_last_q;
  logic [AddrW-1:0] r_idx_q, m_idx_q, p_idx_q, prev_idx_q;
  logic signed [26:0] mx_q, my_q;
  logic [10:0] mt_q, pt_q, prev_t_q;
  logic signed [CoordW-1:0] px_q, py_q, prev_x_q, prev_y_q, first_x_q, first_y_q;

  logic [CntW-1:0] n, expected;
  logic issue, we, box, e_valid, eo_valid;
  logic [RamW-1:0] rdata;
  logic signed [15:0] rx, ry;
  logic signed [26:0] mxr, myr;
  logic signed [16:0] mxs, mys;
  logic signed [DiffW-1:0] ddx, ddy;
  edge_in_t e_in;
  edge_out_t e_out;

  always_comb begin
    if (cfg_i.vcount < 7'd2) begin
      n = CntW'(2);
    end else if (32'(cfg_i.vcount) > 32'(MaxVertices)) begin
      n = CntW'(MaxVertices);
    end else begin
      n = CntW'(cfg_i.vcount);
    end
  end

  assign expected = cfg_i.closed ? n : n - CntW'(1);
  assign pop_o = (state_q == StIdle) && avail_i;
  assign we = pop_o && (item_i.op == OpLoad) && (32'(item_i.vidx) < 32'(MaxVertices));
  assign issue = (state_q == StRun) && (rd_cnt_q < n);

  pht_ram #(
    .Width(RamW),
    .Depth(MaxVertices)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(AddrW'(item_i.vidx)),
    .wdata_i({item_i.base_x, item_i.base_y, item_i.thick}),
    .re_i   (issue),
    .raddr_i(rd_cnt_q[AddrW-1:0]),
    .rdata_o(rdata)
  );

  assign rx = signed'(rdata[42:27]);
  assign ry = signed'(rdata[26:11]);
  assign mxr = mx_q + Round;
  assign myr = my_q + Round;
  assign mxs = 17'(mxr >>> ScaleShift);
  assign mys = 17'(myr >>> ScaleShift);

  assign ddx = DiffW'(qx_q) - DiffW'(px_q);
  assign ddy = DiffW'(qy_q) - DiffW'(py_q);
  assign box = (ddx >= BoxLo) && (ddx <= BoxHi) && (ddy >= BoxLo) && (ddy <= BoxHi);

  assign e_valid = wrap_q || (p_v_q && (p_idx_q != '0));
  assign e_in = '{ax: prev_x_q, ay: prev_y_q,
                  bx: wrap_q ? first_x_q : px_q,
                  by: wrap_q ? first_y_q : py_q,
                  thick: prev_t_q, idx: prev_idx_q, ray_en: cfg_i.closed};

  pht_edge u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(e_valid),
    .edge_i (e_in),
    .qx_i   (qx_q),
    .qy_i   (qy_q),
    .valid_o(eo_valid),
    .res_o  (e_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rd_cnt_q <= '0;
      edge_cnt_q <= '0;
      vhit_q <= 1'b0;
      shit_q <= 1'b0;
      inside_q <= 1'b0;
      vidx_q <= '0;
      sidx_q <= '0;
      wrap_q <= 1'b0;
      r_v_q <= 1'b0;
      m_v_q <= 1'b0;
      p_v_q <= 1'b0;
      out_valid_q <= 1'b0;
      res_q <= '0;
    end else begin
      r_v_q <= issue;
      m_v_q <= r_v_q;
      p_v_q <= m_v_q;
      wrap_q <= p_v_q && p_last_q && cfg_i.closed;
      if (issue) begin
        rd_cnt_q <= rd_cnt_q + CntW'(1);
      end
      if (p_v_q && box && !vhit_q) begin
        vhit_q <= 1'b1;
        vidx_q <= p_idx_q;
      end
      if (eo_valid) begin
        edge_cnt_q <= edge_cnt_q + CntW'(1);
        inside_q <= inside_q ^ e_out.toggle;
        if (e_out.near && !shit_q) begin
          shit_q <= 1'b1;
          sidx_q <= e_out.idx;
        end
      end
      if (out_valid_q && !out_stall_i && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (pop_o && (item_i.op == OpQuery)) begin
            rd_cnt_q <= '0;
            edge_cnt_q <= '0;
            vhit_q <= 1'b0;
            shit_q <= 1'b0;
            inside_q <= 1'b0;
            vidx_q <= '0;
            sidx_q <= '0;
            state_q <= StRun;
          end
        end
        StRun: begin
          if (edge_cnt_q == expected) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            res_q.in_poly <= cfg_i.closed ? inside_q : shit_q;
            res_q.vhit <= vhit_q;
            res_q.vidx <= 6'(vidx_q);
            res_q.shit <= shit_q;
            res_q.sidx <= 6'(sidx_q);
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && (item_i.op == OpQuery)) begin
      qx_q <= item_i.qx;
      qy_q <= item_i.qy;
    end
    r_idx_q <= rd_cnt_q[AddrW-1:0];
    r_last_q <= (rd_cnt_q == n - CntW'(1));
    mx_q <= rx * $signed({1'b0, cfg_i.scale_x});
    my_q <= ry * $signed({1'b0, cfg_i.scale_y});
    mt_q <= rdata[10:0];
    m_idx_q <= r_idx_q;
    m_last_q <= r_last_q;
    px_q <= CoordW'(cfg_i.off_x) + CoordW'(mxs);
    py_q <= CoordW'(cfg_i.off_y) + CoordW'(mys);
    pt_q <= mt_q;
    p_idx_q <= m_idx_q;
    p_last_q <= m_last_q;
    if (p_v_q) begin
      prev_x_q <= px_q;
      prev_y_q <= py_q;
      prev_t_q <= pt_q;
      prev_idx_q <= p_idx_q;
      if (p_idx_q == '0) begin
        first_x_q <= px_q;
        first_y_q <= py_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o = res_q;

endmodule

>>> tb/tb_polygon_point_hit_test.sv
// Self-checking testbench for the polygon point hit test block with an exact hit predictor.
module tb_polygon_point_hit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pht_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               operation_i = 1'b0;
  logic [5:0]         vertex_index_i = '0;
  logic signed [15:0] base_x_i = '0;
  logic signed [15:0] base_y_i = '0;
  logic [10:0]        side_thickness_i = '0;
  logic signed [20:0] query_x_i = '0;
  logic signed [20:0] query_y_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               inside_res_o;
  logic               vertex_hit_o;
  logic [5:0]         hit_vertex_index_o;
  logic               side_hit_o;
  logic [5:0]         hit_side_index_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [20:0]        cfg_data_i = '0;

  polygon_point_hit_test u_dut (.*);

  logic [15:0]        shape_x[MaxVertices];
  logic [15:0]        shape_y[MaxVertices];
  logic [10:0]        shape_thick[MaxVertices];
  logic               m_closed = 1'b1;
  logic [6:0]         m_count = 7'd2;
  logic signed [20:0] m_off_x = '0;
  logic signed [20:0] m_off_y = '0;
  logic [9:0]         m_scale_x = 10'd100;
  logic [9:0]         m_scale_y = 10'd100;

  result_t hits_pending[$];
  int      errors = 0;
  int      items_sent = 0;
  bit      calm = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int used_count();
    if (m_count < 2) return 2;
    if (m_count > MaxVertices) return MaxVertices;
    return int'(m_count);
  endfunction

  function automatic longint to_px(longint off, logic [15:0] b, logic [9:0] s);
    longint prod;
    prod = longint'($signed(b)) * longint'(s);
    return off + ((prod + RoundHalf) >>> ScaleShift);
  endfunction

  function automatic longint vx(int i);
    return to_px(longint'(m_off_x), shape_x[i], m_scale_x);
  endfunction

  function automatic longint vy(int i);
    return to_px(longint'(m_off_y), shape_y[i], m_scale_y);
  endfunction

  function automatic bit side_close(longint ax, longint ay, longint bx, longint by,
                                    longint qx, longint qy, logic [10:0] th);
    longint dx, dy, wx, wy, dot, cr, l2, tt;
    logic [127:0] c2, lhs, rhs;
    dx = bx - ax;
    dy = by - ay;
    wx = qx - ax;
    wy = qy - ay;
    tt = (longint'(th) + TolTwice) * (longint'(th) + TolTwice);
    l2 = dx * dx + dy * dy;
    if (l2 == 0) return 1'b0;
    dot = wx * dx + wy * dy;
    if (dot <= 0) return 4 * (wx * wx + wy * wy) <= tt;
    if (dot >= l2) return 4 * ((qx - bx) * (qx - bx) + (qy - by) * (qy - by)) <= tt;
    cr = wx * dy - wy * dx;
    if (cr < 0) cr = -cr;
    c2 = 128'(cr) * 2;
    lhs = c2 * c2;
    rhs = 128'(tt) * 128'(l2);
    return lhs <= rhs;
  endfunction

  function automatic result_t predict_hit(logic signed [20:0] qxs, logic signed [20:0] qys);
    result_t r;
    int n, nsides, j, nx;
    longint px[MaxVertices];
    longint py[MaxVertices];
    longint qx, qy, dyv, l, rr;
    bit ai, aj, left;
    r = '0;
    n = used_count();
    qx = longint'(qxs);
    qy = longint'(qys);
    for (int i = 0; i < n; i++) begin
      px[i] = vx(i);
      py[i] = vy(i);
      if (!r.vhit && qx >= px[i] - HandleHalf && qx <= px[i] + HandleHalf &&
          qy >= py[i] - HandleHalf && qy <= py[i] + HandleHalf) begin
        r.vhit = 1'b1;
        r.vidx = 6'(i);
      end
    end
    nsides = m_closed ? n : n - 1;
    for (int i = 0; i < nsides && !r.shit; i++) begin
      nx = (i + 1 == n) ? 0 : i + 1;
      if (side_close(px[i], py[i], px[nx], py[nx], qx, qy, shape_thick[i])) begin
        r.shit = 1'b1;
        r.sidx = 6'(i);
      end
    end
    if (m_closed) begin
      j = n - 1;
      for (int i = 0; i < n; i++) begin
        ai = py[i] > qy;
        aj = py[j] > qy;
        if (ai != aj) begin
          dyv = py[j] - py[i];
          l = (qx - px[i]) * dyv;
          rr = (px[j] - px[i]) * (qy - py[i]);
          left = (dyv > 0) ? (l < rr) : (l > rr);
          if (left) r.in_poly = ~r.in_poly;
        end
        j = i;
      end
    end else begin
      r.in_poly = r.shit;
    end
    return r;
  endfunction

  task automatic send_item(op_e op, logic [5:0] idx, logic [15:0] bx, logic [15:0] by,
                           logic [10:0] th, logic [20:0] qx, logic [20:0] qy);
    if (!calm && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    vertex_index_i <= idx;
    base_x_i <= bx;
    base_y_i <= by;
    side_thickness_i <= th;
    query_x_i <= qx;
    query_y_i <= qy;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (op == OpLoad) begin
      shape_x[idx] = bx;
      shape_y[idx] = by;
      shape_thick[idx] = th;
    end else begin
      hits_pending.push_back(predict_hit(qx, qy));
    end
  endtask

  task automatic load_vertex(int idx, logic [15:0] bx, logic [15:0] by, logic [10:0] th);
    send_item(OpLoad, 6'(idx), bx, by, th, 21'($urandom), 21'($urandom));
  endtask

  task automatic query_point(longint qx, longint qy);
    send_item(OpQuery, 6'($urandom), 16'($urandom), 16'($urandom), 11'($urandom),
              21'(qx), 21'(qy));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (hits_pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [20:0] value);
    wait_drained();
    repeat (100) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgClosedMode:  m_closed = value[0];
      CfgVertexCount: m_count = value[6:0];
      CfgOffsetX:     m_off_x = value;
      CfgOffsetY:     m_off_y = value;
      CfgScaleX:      m_scale_x = value[9:0];
      CfgScaleY:      m_scale_y = value[9:0];
      default: ;
    endcase
  endtask

  task automatic random_query();
    int k, i, j, t;
    longint x, y;
    k = $urandom_range(99);
    i = $urandom_range(used_count() - 1);
    j = (i + 1) % used_count();
    if (k < 35) begin
      x = vx(i) + longint'($urandom_range(256)) - 128;
      y = vy(i) + longint'($urandom_range(256)) - 128;
    end else if (k < 70) begin
      t = $urandom_range(16);
      x = vx(i) + (vx(j) - vx(i)) * t / 16 + longint'($urandom_range(600)) - 300;
      y = vy(i) + (vy(j) - vy(i)) * t / 16 + longint'($urandom_range(600)) - 300;
    end else if (k < 90) begin
      x = to_px(longint'(m_off_x), 16'($urandom_range(32767) - 16384), m_scale_x);
      y = to_px(longint'(m_off_y), 16'($urandom_range(32767) - 16384), m_scale_y);
    end else begin
      x = longint'($urandom);
      y = longint'($urandom);
    end
    query_point(x, y);
  endtask

  task automatic random_shape(int n);
    logic [15:0] bx, by;
    logic [10:0] th;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        bx = 16'($urandom);
        by = 16'($urandom);
      end else begin
        bx = 16'($urandom_range(32767) - 16384);
        by = 16'($urandom_range(32767) - 16384);
      end
      if (i > 0 && $urandom_range(19) == 0) begin
        bx = shape_x[i - 1];
        by = shape_y[i - 1];
      end
      th = ($urandom_range(19) == 0) ? 11'($urandom) : 11'($urandom_range(16, 1600));
      load_vertex(i, bx, by, th);
    end
  endtask

  task automatic test_directed();
    load_vertex(0, 16'sd0, 16'sd0, 11'd16);
    load_vertex(1, 16'sd16384, 16'sd0, 11'd1600);
    query_point(0, 0);
    query_point(96, -96);
    query_point(97, 0);
    query_point(800, 0);
    query_point(800, 200);
    query_point(1600, 96);
    query_point(3000, 3000);
    query_point(-1048576, 1048575);
    query_point(1048575, -1048576);
    load_vertex(1, 16'sd0, 16'sd0, 11'd0);
    query_point(50, 50);
    query_point(0, 300);
    load_vertex(0, 16'h8000, 16'h7FFF, 11'd2047);
    load_vertex(1, 16'h7FFF, 16'h8000, 11'd0);
    query_point(0, 0);
    query_point(-1600, 1600);
    query_point(1600, -1600);
  endtask

  task automatic test_registers();
    random_shape(MaxVertices);
    write_reg(CfgVertexCount, 21'd3);
    repeat (6) random_query();
    write_reg(CfgClosedMode, 21'd0);
    write_reg(CfgVertexCount, 21'd0);
    repeat (6) random_query();
    write_reg(CfgVertexCount, 21'd1);
    repeat (6) random_query();
    write_reg(CfgVertexCount, 21'h1FFFFF);
    repeat (6) random_query();
    write_reg(CfgClosedMode, 21'h1FFFFF);
    write_reg(CfgVertexCount, 21'd64);
    repeat (6) random_query();
    write_reg(CfgOffsetX, 21'h0FFFFF);
    write_reg(CfgOffsetY, 21'h100000);
    repeat (6) random_query();
    write_reg(CfgOffsetX, 21'h100000);
    write_reg(CfgOffsetY, 21'h0FFFFF);
    write_reg(CfgScaleX, 21'd0);
    write_reg(CfgScaleY, 21'h1FFFFF);
    repeat (6) random_query();
    write_reg(CfgScaleX, 21'd1023);
    write_reg(CfgScaleY, 21'd1);
    write_reg(3'd6, 21'h1FFFFF);
    write_reg(3'd7, 21'd0);
    repeat (6) random_query();
  endtask

  task automatic test_random();
    int n, k, phase;
    phase = 0;
    while (items_sent < 1850) begin
      k = $urandom_range(99);
      n = (k < 60) ? $urandom_range(3, 12) : (k < 90) ? $urandom_range(13, 40)
                                                      : $urandom_range(41, MaxVertices);
      calm = (phase % 8 == 5);
      write_reg(CfgClosedMode, 21'($urandom_range(1)));
      write_reg(CfgVertexCount, 21'(n));
      if ($urandom_range(9) == 0) begin
        write_reg(CfgOffsetX, 21'($urandom));
        write_reg(CfgOffsetY, 21'($urandom));
      end else begin
        write_reg(CfgOffsetX, 21'($urandom_range(80000) - 40000));
        write_reg(CfgOffsetY, 21'($urandom_range(80000) - 40000));
      end
      write_reg(CfgScaleX, 21'(($urandom_range(29) == 0) ? 0 : $urandom_range(1, 1023)));
      write_reg(CfgScaleY, 21'(($urandom_range(29) == 0) ? 0 : $urandom_range(1, 1023)));
      random_shape(n);
      for (int q = 0; q < 30; q++) begin
        random_query();
        if (q == 15 && phase % 4 == 1) wait_drained();
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 18);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hits_pending.size() == 0) begin
        errors++;
        $display("%0t: result with none expected", $time);
      end else begin
        want = hits_pending.pop_front();
        if (inside_res_o !== want.in_poly) begin
          errors++;
          $display("%0t: inside_res expected %0d actual %0d", $time, want.in_poly,
                   inside_res_o);
        end
        if (vertex_hit_o !== want.vhit) begin
          errors++;
          $display("%0t: vertex_hit expected %0d actual %0d", $time, want.vhit,
                   vertex_hit_o);
        end
        if (hit_vertex_index_o !== want.vidx) begin
          errors++;
          $display("%0t: hit_vertex_index expected %0d actual %0d", $time, want.vidx,
                   hit_vertex_index_o);
        end
        if (side_hit_o !== want.shit) begin
          errors++;
          $display("%0t: side_hit expected %0d actual %0d", $time, want.shit, side_hit_o);
        end
        if (hit_side_index_o !== want.sidx) begin
          errors++;
          $display("%0t: hit_side_index expected %0d actual %0d", $time, want.sidx,
                   hit_side_index_o);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("polygon_point_hit_test: mismatch");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_registers();
    test_random();
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("polygon_point_hit_test: match");
    end else begin
      $display("polygon_point_hit_test: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/pht_pkg.sv
hdl/pht_ram.sv
hdl/pht_front.sv
hdl/pht_edge.sv
hdl/pht_back.sv
hdl/polygon_point_hit_test.sv
tb/tb_polygon_point_hit_test.sv
